FILE: hw/rtl/minla_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// minla_pkg
// Shared types and constants of the arrangement swap engine: request and
// response payloads, request kinds and controller states.
// ---------------------------------------------------------------------------
package minla_pkg;

   // default sizes of the graph tables
   localparam int MAX_NODES_DEF   = 1024;
   localparam int MAX_ENTRIES_DEF = 8192;

   // field widths
   localparam int KIND_W   = 2;
   localparam int NODE_W   = 11;
   localparam int OTHER_W  = 10;
   localparam int POS_W    = 14;
   localparam int BUDGET_W = 25;
   localparam int DELTA_W  = 26;
   localparam int ENERGY_W = 24;

   // node count after reset
   localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1024;

   // saturation limits
   localparam logic [ENERGY_W-1:0]       ENERGY_MAX = {ENERGY_W{1'b1}};
   localparam logic signed [DELTA_W-1:0] DELTA_MAX  = {1'b0, {(DELTA_W-1){1'b1}}};
   localparam logic signed [DELTA_W-1:0] DELTA_MIN  = {1'b1, {(DELTA_W-1){1'b0}}};

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_OFFSET = 2'd0,
      KIND_LOAD_ENTRY  = 2'd1,
      KIND_PROPOSE     = 2'd2,
      KIND_NONE        = 2'd3
   } kind_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [NODE_W-1:0]   node;
      logic [OTHER_W-1:0]  other_node;
      logic [POS_W-1:0]    position;
      logic [BUDGET_W-1:0] uphill_budget;
   } req_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] delta;
      logic                      accepted;
      logic [ENERGY_W-1:0]       energy;
      logic [ENERGY_W-1:0]       best_energy;
      logic                      new_best;
      logic                      bad_pair;
   } rsp_type;

   // controller states
   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_LD_B,
      ST_LD_C,
      ST_P_RV,
      ST_P_RV2,
      ST_P_LSA,
      ST_P_LSB,
      ST_P_LSC,
      ST_W_NL,
      ST_W_RK,
      ST_W_ACC,
      ST_P_DEC,
      ST_SW_U,
      ST_SW_V,
      ST_RESULT
   } state_type;

endpackage : minla_pkg
`default_nettype wire

FILE: hw/rtl/minla_annealing_swap_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// minla_annealing_swap_engine
// Keeps a graph in offset/neighbor tables and a rank per node; loads build
// the energy, proposals evaluate a rank swap and apply it when it pays off.
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  minla_pkg::req_type
//  rsp_      out        rsp_valid / rsp_stall  minla_pkg::rsp_type
//  csr_      in         csr_wr_en              node count (11 bits)
//
//  A proposal walks the neighbors of both nodes; every neighbor costs one
//  neighbor-table read and one rank-memory read on the single read ports
//  (W_NL, W_RK), a skipped entry leaves out W_ACC, and an applied swap adds
//  the rank writes SW_U and SW_V.
//  After reset the rank memory is swept to the identity order; requests
//  are stalled during the sweep.
//  A result waiting on rsp_stall holds the engine once the next result is ready.
`default_nettype none
module minla_annealing_swap_engine #(
   parameter int MAX_NODES   = minla_pkg::MAX_NODES_DEF,
   parameter int MAX_ENTRIES = minla_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire minla_pkg::req_type        req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output minla_pkg::rsp_type             rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [minla_pkg::NODE_W-1:0] csr_wr_data
);
   import minla_pkg::*;

   localparam int RK_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int LS_W  = $clog2(MAX_NODES + 1);
   localparam int EN_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int IDX_W = EN_W + 1;
   localparam int SUM_W = RK_W + EN_W + 3;
   localparam int CMP_W = (SUM_W + 1 > DELTA_W + 1) ? SUM_W + 1 : DELTA_W + 1;
   localparam int EA_W  = DELTA_W + 1;

   // memories
   logic [RK_W-1:0]    rank_mem [MAX_NODES];
   logic [POS_W-1:0]   ls_mem   [MAX_NODES+1];
   logic [OTHER_W-1:0] nl_mem   [MAX_ENTRIES];

   state_type state_ff, state_in;
   req_type   req_q_ff;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;

   logic [RK_W-1:0]      init_cnt_ff;
   logic [NODE_W-1:0]    node_count_ff;
   logic [ENERGY_W-1:0]  energy_ff, best_ff;
   logic [RK_W-1:0]      ru_ff, rv_ff;
   logic [POS_W-1:0]     lo_ff;
   logic [IDX_W-1:0]     idx_ff, hi_ff;
   logic                 side_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [DELTA_W-1:0] delta_ff;
   logic accepted_ff, new_best_ff, bad_ff;

   // memory ports
   logic [RK_W-1:0]    rank_raddr, rank_waddr, rank_wdata, rank_q;
   logic               rank_we;
   logic [LS_W-1:0]    ls_raddr;
   logic               ls_we;
   logic [POS_W-1:0]   ls_q;
   logic               nl_we;
   logic [OTHER_W-1:0] nl_q;

   // decode helpers
   logic [NODE_W-1:0] other_ext, a_node, b_node;
   logic [RK_W-1:0]   ra_side, rb_side, ad_b, ad_a;
   logic              off_ok, ent_ok, pair_bad, w_skip, accept;
   logic signed [RK_W:0]      term;
   logic signed [SUM_W:0]     dbl;
   logic signed [CMP_W-1:0]   dbl_ext;
   logic signed [DELTA_W-1:0] dsat;
   logic signed [DELTA_W-1:0] e_inc;
   logic signed [EA_W-1:0]    e_sum;
   logic [ENERGY_W-1:0]       e_clamped;
   logic [RK_W-1:0]           ld_gap;

   function automatic logic [IDX_W-1:0] ent_clamp(input logic [POS_W-1:0] x);
      if (32'(x) > 32'(MAX_ENTRIES)) begin
         return IDX_W'(MAX_ENTRIES);
      end
      return IDX_W'(x);
   endfunction

   assign other_ext = NODE_W'(req_q_ff.other_node);
   assign a_node    = side_ff ? other_ext : req_q_ff.node;
   assign b_node    = side_ff ? req_q_ff.node : other_ext;
   assign ra_side   = side_ff ? rv_ff : ru_ff;
   assign rb_side   = side_ff ? ru_ff : rv_ff;

   // request checks
   assign off_ok   = 32'(req_q_ff.node) <= 32'(MAX_NODES);
   assign ent_ok   = (32'(req_q_ff.node) < 32'(MAX_NODES))
                   && (32'(req_q_ff.other_node) < 32'(MAX_NODES))
                   && (32'(req_q_ff.position) < 32'(MAX_ENTRIES));
   assign pair_bad = (req_q_ff.node == other_ext) || (req_q_ff.node >= node_count_ff)
                   || (other_ext >= node_count_ff);
   assign w_skip   = (NODE_W'(nl_q) == b_node) || (32'(nl_q) >= 32'(MAX_NODES));

   // gap change of one neighbor
   assign ad_b = (rb_side > rank_q) ? rb_side - rank_q : rank_q - rb_side;
   assign ad_a = (ra_side > rank_q) ? ra_side - rank_q : rank_q - ra_side;
   assign term = $signed({1'b0, ad_b}) - $signed({1'b0, ad_a});

   // doubled and saturated delta
   assign dbl     = {sum_ff, 1'b0};
   assign dbl_ext = CMP_W'(dbl);
   always_comb begin
      priority if (dbl_ext > CMP_W'(DELTA_MAX)) begin
         dsat = DELTA_MAX;
      end else if (dbl_ext < CMP_W'(DELTA_MIN)) begin
         dsat = DELTA_MIN;
      end else begin
         dsat = DELTA_W'(dbl_ext);
      end
   end
   assign accept = dsat[DELTA_W-1]
                 || (dsat[BUDGET_W-1:0] < req_q_ff.uphill_budget);

   // energy update with saturation, shared by load and swap
   assign ld_gap = (ru_ff > rank_q) ? ru_ff - rank_q : rank_q - ru_ff;
   assign e_inc  = (state_ff == ST_LD_C) ? DELTA_W'({1'b0, ld_gap}) : dsat;
   assign e_sum  = $signed({3'b000, energy_ff}) + EA_W'(e_inc);
   always_comb begin
      priority if (e_sum < 0) begin
         e_clamped = '0;
      end else if (e_sum > $signed(EA_W'(ENERGY_MAX))) begin
         e_clamped = ENERGY_MAX;
      end else begin
         e_clamped = ENERGY_W'(e_sum);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (init_cnt_ff == RK_W'(MAX_NODES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (kind_type'(req_q_ff.kind))
               KIND_LOAD_ENTRY: state_in = ent_ok ? ST_LD_B : ST_RESULT;
               KIND_PROPOSE:    state_in = pair_bad ? ST_RESULT : ST_P_RV;
               default:         state_in = ST_RESULT;
            endcase
         end
         ST_LD_B:  state_in = ST_LD_C;
         ST_LD_C:  state_in = ST_RESULT;
         ST_P_RV:  state_in = ST_P_RV2;
         ST_P_RV2: state_in = ST_P_LSA;
         ST_P_LSA: state_in = ST_P_LSB;
         ST_P_LSB: state_in = ST_P_LSC;
         ST_P_LSC: state_in = ST_W_NL;
         ST_W_NL: begin
            if (idx_ff >= hi_ff) state_in = side_ff ? ST_P_DEC : ST_P_LSA;
            else state_in = ST_W_RK;
         end
         ST_W_RK:  state_in = w_skip ? ST_W_NL : ST_W_ACC;
         ST_W_ACC: state_in = ST_W_NL;
         ST_P_DEC: state_in = accept ? ST_SW_U : ST_RESULT;
         ST_SW_U:  state_in = ST_SW_V;
         ST_SW_V:  state_in = ST_RESULT;
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      rank_raddr = RK_W'(req_q_ff.node);
      rank_waddr = init_cnt_ff;
      rank_wdata = init_cnt_ff;
      rank_we    = 1'b0;
      ls_raddr   = LS_W'(a_node);
      ls_we      = 1'b0;
      nl_we      = 1'b0;
      req_stall  = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_INIT: rank_we = 1'b1;
         ST_DECODE: begin
            ls_we = (kind_type'(req_q_ff.kind) == KIND_LOAD_OFFSET) && off_ok;
            nl_we = (kind_type'(req_q_ff.kind) == KIND_LOAD_ENTRY) && ent_ok;
         end
         ST_LD_B:  rank_raddr = RK_W'(req_q_ff.other_node);
         ST_P_RV:  rank_raddr = RK_W'(req_q_ff.other_node);
         ST_P_LSB: ls_raddr = LS_W'(a_node) + LS_W'(1);
         ST_W_RK:  rank_raddr = RK_W'(nl_q);
         ST_SW_U: begin
            rank_we    = 1'b1;
            rank_waddr = RK_W'(req_q_ff.node);
            rank_wdata = rv_ff;
         end
         ST_SW_V: begin
            rank_we    = 1'b1;
            rank_waddr = RK_W'(req_q_ff.other_node);
            rank_wdata = ru_ff;
         end
         default: ;
      endcase
   end

   // rank memory
   always_ff @(posedge clock) begin
      if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
      rank_q <= rank_mem[rank_raddr];
   end

   // offset memory
   always_ff @(posedge clock) begin
      if (ls_we) ls_mem[LS_W'(req_q_ff.node)] <= req_q_ff.position;
      ls_q <= ls_mem[ls_raddr];
   end

   // neighbor memory
   always_ff @(posedge clock) begin
      if (nl_we) nl_mem[EN_W'(req_q_ff.position)] <= req_q_ff.other_node;
      nl_q <= nl_mem[idx_ff[EN_W-1:0]];
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_cnt_ff   <= '0;
         node_count_ff <= NODE_COUNT_RST;
         energy_ff     <= '0;
         best_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            node_count_ff <= (32'(csr_wr_data) > 32'(MAX_NODES))
                           ? NODE_W'(MAX_NODES) : csr_wr_data;
         end
         // response register: load a new result or retire the taken one
         if ((state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: init_cnt_ff <= init_cnt_ff + 1'b1;
            ST_IDLE: begin
               req_q_ff <= req_data;
            end
            ST_DECODE: begin
               delta_ff    <= '0;
               accepted_ff <= 1'b0;
               new_best_ff <= 1'b0;
               bad_ff      <= 1'b0;
               sum_ff      <= '0;
               side_ff     <= 1'b0;
               unique case (kind_type'(req_q_ff.kind))
                  KIND_LOAD_OFFSET: best_ff <= energy_ff;
                  KIND_LOAD_ENTRY: if (!ent_ok) best_ff <= energy_ff;
                  KIND_PROPOSE: bad_ff <= pair_bad;
                  default: ;
               endcase
            end
            ST_LD_B: ru_ff <= rank_q;
            ST_LD_C: begin
               energy_ff <= e_clamped;
               best_ff   <= e_clamped;
            end
            ST_P_RV:  ru_ff <= rank_q;
            ST_P_RV2: rv_ff <= rank_q;
            ST_P_LSB: lo_ff <= ls_q;
            ST_P_LSC: begin
               idx_ff <= ent_clamp(lo_ff);
               hi_ff  <= ent_clamp(ls_q);
            end
            ST_W_NL: begin
               if (idx_ff >= hi_ff) side_ff <= 1'b1;
            end
            ST_W_RK: begin
               if (w_skip) idx_ff <= idx_ff + 1'b1;
            end
            ST_W_ACC: begin
               sum_ff <= sum_ff + SUM_W'(term);
               idx_ff <= idx_ff + 1'b1;
            end
            ST_P_DEC: begin
               delta_ff <= dsat;
               if (accept) begin
                  accepted_ff <= 1'b1;
                  energy_ff   <= e_clamped;
                  if (e_clamped <= best_ff) begin
                     best_ff     <= e_clamped;
                     new_best_ff <= 1'b1;
                  end
               end
            end
            ST_RESULT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.delta        <= delta_ff;
                  rsp_ff.accepted     <= accepted_ff;
                  rsp_ff.energy       <= energy_ff;
                  rsp_ff.best_energy  <= best_ff;
                  rsp_ff.new_best     <= new_best_ff;
                  rsp_ff.bad_pair     <= bad_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // an accepted request always goes to decode
   a_req_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted request did not enter decode");

   // best energy never above current energy
   a_best_le_energy: assert property (@(posedge clock) disable iff (reset)
      best_ff <= energy_ff)
      else $error("best energy above current energy");

   // new best only on an applied swap, never on a bad pair
   a_new_best_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.new_best || rsp_ff.accepted)
                       && !(rsp_ff.accepted && rsp_ff.bad_pair))
      else $error("inconsistent response flags");

   // walk reads stay inside the list
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W_RK) |-> (idx_ff < hi_ff))
      else $error("neighbor walk past list end");
`endif

endmodule : minla_annealing_swap_engine
`default_nettype wire

FILE: dv/minla_checker.sv
// ---------------------------------------------------------------------------
// minla_checker
// Watches the request, response and csr ports of the swap engine, keeps its
// own copy of ranks, tables and energies, and compares every response with
// the oldest predicted one. Hands the mismatch count and the number of
// outstanding responses to the testbench top.
// ---------------------------------------------------------------------------
module minla_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  minla_pkg::req_type            req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  minla_pkg::rsp_type            rsp_data,
   input  logic                          csr_wr_en,
   input  logic [minla_pkg::NODE_W-1:0]  csr_wr_data,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import minla_pkg::*;

   localparam int NODES   = MAX_NODES_DEF;
   localparam int ENTRIES = MAX_ENTRIES_DEF;

   logic [9:0]  rank_tbl [NODES];
   logic [13:0] start_tbl [NODES+1];
   logic [9:0]  nbr_tbl [ENTRIES];
   longint      energy_now;
   longint      energy_low;
   int          nodes_used;
   rsp_type     rsp_queue [$];

   assign pending = rsp_queue.size();

   function automatic longint gap(longint a, longint b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic longint clamp_energy(longint e);
      if (e < 0) return 0;
      if (e > longint'(ENERGY_MAX)) return longint'(ENERGY_MAX);
      return e;
   endfunction

   // cost change over node a's list if a took b's rank, b's edge skipped
   function automatic longint list_change(int a, int b);
      int     lo;
      int     hi;
      int     w;
      longint sum;
      lo  = start_tbl[a];
      hi  = start_tbl[a+1];
      sum = 0;
      if (lo > ENTRIES) lo = ENTRIES;
      if (hi > ENTRIES) hi = ENTRIES;
      for (int i = lo; i < hi; i++) begin
         w = nbr_tbl[i];
         if (w != b) begin
            sum += gap(rank_tbl[b], rank_tbl[w]) - gap(rank_tbl[a], rank_tbl[w]);
         end
      end
      return sum;
   endfunction

   // apply one request to the shadow state, return the response it causes
   function automatic rsp_type swap_outcome(req_type r);
      rsp_type    o;
      int         u;
      int         v;
      longint     d;
      logic [9:0] t;
      u = r.node;
      v = r.other_node;
      d = 0;
      o = '0;
      case (kind_type'(r.kind))
         KIND_LOAD_OFFSET: begin
            if (u <= NODES) start_tbl[u] = r.position;
            energy_low = energy_now;
         end
         KIND_LOAD_ENTRY: begin
            if (u < NODES && r.position < ENTRIES) begin
               nbr_tbl[r.position] = r.other_node;
               energy_now = clamp_energy(energy_now + gap(rank_tbl[u], rank_tbl[v]));
            end
            energy_low = energy_now;
         end
         KIND_PROPOSE: begin
            if (u == v || u >= nodes_used || v >= nodes_used) begin
               o.bad_pair = 1'b1;
            end else begin
               d = 2 * (list_change(u, v) + list_change(v, u));
               if (d > longint'(DELTA_MAX)) d = longint'(DELTA_MAX);
               if (d < longint'(DELTA_MIN)) d = longint'(DELTA_MIN);
               if (d < 0 || d < longint'(r.uphill_budget)) begin
                  t           = rank_tbl[u];
                  rank_tbl[u] = rank_tbl[v];
                  rank_tbl[v] = t;
                  o.accepted  = 1'b1;
                  energy_now  = clamp_energy(energy_now + d);
                  if (energy_now <= energy_low) begin
                     energy_low = energy_now;
                     o.new_best = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      o.delta       = d[DELTA_W-1:0];
      o.energy      = energy_now[ENERGY_W-1:0];
      o.best_energy = energy_low[ENERGY_W-1:0];
      return o;
   endfunction

   // observe the ports at each rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NODES; i++) rank_tbl[i] = 10'(i);
         for (int i = 0; i <= NODES; i++) start_tbl[i] = '0;
         for (int i = 0; i < ENTRIES; i++) nbr_tbl[i] = '0;
         energy_now = 0;
         energy_low = 0;
         nodes_used = NODES;
         rsp_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            nodes_used = csr_wr_data > NODES ? NODES : csr_wr_data;
         end
         // compare a response before queueing this edge's request
         if (rsp_valid && !rsp_stall) begin
            if (rsp_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               want = rsp_queue.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("response mismatch: expected %p", want);
                     $display("                   actual   %p", rsp_data);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            rsp_queue.insert(rsp_queue.size(), swap_outcome(req_data));
         end
      end
   end

endmodule : minla_checker

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Regression of the annealing swap engine: builds small graphs in the offset
// and neighbor tables, proposes rank swaps under varied node counts and
// uphill budgets, with random gaps and stalls on both channels. The checker
// predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import minla_pkg::*;

   localparam int NODES       = MAX_NODES_DEF;
   localparam int ENTRIES     = MAX_ENTRIES_DEF;
   localparam int ITEM_TARGET = 1550;
   localparam int CALM_AFTER  = 1400;
   localparam int IDLE_LIMIT  = 20000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [NODE_W-1:0] csr_wr_data;
   int                fail_count;
   int                pending;

   // stimulus-side view of what the tables hold
   int                off_val [NODES+1];
   bit                off_set [NODES+1];
   bit                ent_set [ENTRIES];
   int                nodes_used;
   int                sent;
   bit                calm;
   bit                long_hold_done;
   int                idle_cycles;

   minla_annealing_swap_engine u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   minla_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   assign calm = sent >= CALM_AFTER;

   // response side: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      int burst;
      int hold;
      if (reset) begin
         rsp_stall      <= 1'b0;
         burst          = 0;
         hold           = 0;
         long_hold_done = 1'b0;
      end else if (hold > 0) begin
         hold--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && sent >= 300) begin
         long_hold_done = 1'b1;
         hold           = 400;
         rsp_stall      <= 1'b1;
      end else if (burst > 0) begin
         burst--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         burst     = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("minla_annealing_swap_engine regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one request and hold it until accepted
   task automatic send_req(kind_type k, int node, int other, int pos, int budget);
      req_type r;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      r.kind          = k;
      r.node          = NODE_W'(node);
      r.other_node    = OTHER_W'(other);
      r.position      = POS_W'(pos);
      r.uphill_budget = BUDGET_W'(budget);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (k == KIND_LOAD_OFFSET && node <= NODES) begin
         off_val[node] = pos;
         off_set[node] = 1'b1;
      end
      if (k == KIND_LOAD_ENTRY && node < NODES && pos < ENTRIES) ent_set[pos] = 1'b1;
   endtask

   // true when the swap touches no table entry that was never written
   function automatic bit safe_swap(int u, int v);
      int lo;
      int hi;
      if (u == v || u >= nodes_used || v >= nodes_used) return 1'b1;
      foreach (off_set[i]) begin
         if ((i == u || i == v) && !(off_set[i] && off_set[i+1])) return 1'b0;
      end
      for (int s = 0; s < 2; s++) begin
         lo = off_val[s ? v : u];
         hi = off_val[(s ? v : u) + 1];
         if (lo > ENTRIES) lo = ENTRIES;
         if (hi > ENTRIES) hi = ENTRIES;
         for (int i = lo; i < hi; i++) if (!ent_set[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic propose(int u, int v, int budget);
      if (safe_swap(u, v)) send_req(KIND_PROPOSE, u, v, $urandom, budget);
      else send_req(KIND_NONE, u, v, $urandom, budget);
   endtask

   function automatic int pick_budget();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return $urandom_range(1, 3000);
         2:       return $urandom & 32'h1FF_FFFF;
         default: return 32'h1FF_FFFF;
      endcase
   endfunction

   // offsets for nodes 0..g and a neighbor list per node starting at base
   task automatic load_graph(int base, int g, int max_deg);
      int at;
      int deg [];
      deg = new[g];
      at  = base;
      foreach (deg[i]) deg[i] = $urandom_range(0, max_deg);
      for (int i = 0; i <= g; i++) begin
         send_req(KIND_LOAD_OFFSET, i, $urandom, at, $urandom);
         if (i < g) at += deg[i];
      end
      at = base;
      for (int i = 0; i < g; i++) begin
         for (int j = 0; j < deg[i]; j++) begin
            send_req(KIND_LOAD_ENTRY, i,
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                               : $urandom_range(0, g - 1),
                     at, $urandom);
            at++;
         end
      end
   endtask

   // stop offering and let every outstanding response drain
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_node_count(int n);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= NODE_W'(n);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      nodes_used = n > NODES ? NODES : n;
   endtask

   initial begin
      int g;
      int u;
      int v;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      sent        = 0;
      nodes_used  = NODES;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_node_count(NODES);

      // directed: a tiny graph and each corner of the proposal path
      load_graph(0, 5, 3);
      propose(0, 1, 0);
      propose(2, 3, 32'h1FF_FFFF);
      propose(4, 0, 1);
      propose(3, 3, 5);
      propose(1024, 1, 5);
      send_req(KIND_NONE, 2047, 1023, 16383, 32'h1FF_FFFF);
      send_req(KIND_LOAD_OFFSET, 1025, 0, 100, 0);
      send_req(KIND_LOAD_OFFSET, 2047, 0, 100, 0);
      send_req(KIND_LOAD_ENTRY, 1500, 7, 10, 0);
      send_req(KIND_LOAD_ENTRY, 1, 7, 9000, 0);
      // a list that starts past the table comes out empty, one that ends past it is cut at the table end
      send_req(KIND_LOAD_OFFSET, 6, 0, 9000, 0);
      send_req(KIND_LOAD_OFFSET, 7, 0, 16383, 0);
      propose(6, 0, 0);
      propose(6, 5, 32'h1FF_FFFF);
      drain();
      set_node_count(2047);
      propose(1023, 0, 0);
      drain();

      // random phases: configure, build a graph, then many proposals
      while (sent < ITEM_TARGET) begin
         drain();
         case ($urandom_range(0, 3))
            0:       set_node_count(2);
            1:       set_node_count(NODES);
            default: set_node_count($urandom_range(3, 64));
         endcase
         g = nodes_used < 24 ? nodes_used : $urandom_range(2, 24);
         load_graph($urandom_range(0, 8100), g, 4);
         repeat ($urandom_range(20, 80)) begin
            case ($urandom_range(0, 19))
               0:       propose($urandom & 32'h7FF, $urandom & 32'h3FF, pick_budget());
               1:       send_req(kind_type'($urandom_range(0, 1) ? KIND_NONE : KIND_LOAD_ENTRY),
                                 $urandom_range(1024, 2047), $urandom & 32'h3FF,
                                 $urandom & 32'h3FFF, $urandom & 32'h1FF_FFFF);
               2:       send_req(KIND_LOAD_OFFSET, $urandom_range(0, g),
                                 0, $urandom_range(0, 8300), 0);
               default: begin
                  u = $urandom_range(0, g - 1);
                  v = $urandom_range(0, g - 1);
                  propose(u, v, pick_budget());
               end
            endcase
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("minla_annealing_swap_engine regression: pass");
      end else begin
         $display("minla_annealing_swap_engine regression: fail");
      end
      $finish;
   end

endmodule : tb_top

FILE: filelist.f
hw/rtl/minla_pkg.sv
hw/rtl/minla_annealing_swap_engine.sv
dv/minla_checker.sv
dv/tb_top.sv
